// ----- src/cffr_pkg.sv -----
// ----------------------------------------------------------------------------
// cffr_pkg
// Shared types and constants of the checksummed file frame receiver.
// ----------------------------------------------------------------------------
package cffr_pkg;

    localparam int NAME_MAX     = 16;
    localparam int BLOCK_BYTES  = 256;
    localparam int BUFFER_DEPTH = 65536;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 16;
    localparam int COUNT_W    = 17;
    localparam int ERR_W      = 3;
    localparam int NAME_IDX_W = $clog2(NAME_MAX + 1);
    localparam int BLK_W      = $clog2(BLOCK_BYTES);

    localparam int ERR_HEADER = 0;
    localparam int ERR_BLOCK  = 1;
    localparam int ERR_FINAL  = 2;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_NAME   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               item_kind;
        logic [ADDR_W-1:0]   position;
        logic [BYTE_W-1:0]   store_byte;
        logic [ADDR_W-1:0]   start_address;
        logic [ADDR_W-1:0]   end_address;
        logic [ADDR_W-1:0]   exec_address;
        logic [BYTE_W-1:0]   file_type;
        logic [COUNT_W-1:0]  byte_count;
        logic [ERR_W-1:0]    error_bits;
        logic                save_allowed;
    } t_result;

endpackage

// ----- src/cffr_deframer.sv -----
// ----------------------------------------------------------------------------
// cffr_deframer
// Frame parser: walks the header, name, data and checksum fields one word at
// a time and forms at most one result per accepted word.
// ----------------------------------------------------------------------------
module cffr_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic                           i_cmd,
    input  logic [cffr_pkg::BYTE_W-1:0]    i_link_byte,
    output logic                           o_res_valid,
    output cffr_pkg::t_result              o_res
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_A0   = 4'd1,
        PH_A1   = 4'd2,
        PH_A2   = 4'd3,
        PH_A3   = 4'd4,
        PH_A4   = 4'd5,
        PH_A5   = 4'd6,
        PH_TYPE = 4'd7,
        PH_NAME = 4'd8,
        PH_HSUM = 4'd9,
        PH_DATA = 4'd10,
        PH_BSUM = 4'd11,
        PH_FSUM = 4'd12,
        PH_DONE = 4'd13
    } t_phase;

    t_phase                                r_phase, n_phase;
    logic [cffr_pkg::ADDR_W-1:0]           r_start_word, n_start_word;
    logic [cffr_pkg::ADDR_W-1:0]           r_end_word, n_end_word;
    logic [cffr_pkg::ADDR_W-1:0]           r_exec_word, n_exec_word;
    logic [cffr_pkg::BYTE_W-1:0]           r_type_byte, n_type_byte;
    logic [cffr_pkg::COUNT_W-1:0]          r_frame_length, n_frame_length;
    logic [cffr_pkg::NAME_IDX_W-1:0]       r_name_index, n_name_index;
    logic [cffr_pkg::BYTE_W-1:0]           r_header_sum, n_header_sum;
    logic [cffr_pkg::BYTE_W-1:0]           r_data_sum, n_data_sum;
    logic [cffr_pkg::COUNT_W-1:0]          r_data_index, n_data_index;
    logic [cffr_pkg::ERR_W-1:0]            r_error_flags, n_error_flags;

    logic [cffr_pkg::ADDR_W-1:0]           len16;
    logic                                  final_ok;

    assign len16 = r_end_word - r_start_word + cffr_pkg::ADDR_W'(1);

    always_comb begin
        n_phase        = r_phase;
        n_start_word   = r_start_word;
        n_end_word     = r_end_word;
        n_exec_word    = r_exec_word;
        n_type_byte    = r_type_byte;
        n_frame_length = r_frame_length;
        n_name_index   = r_name_index;
        n_header_sum   = r_header_sum;
        n_data_sum     = r_data_sum;
        n_data_index   = r_data_index;
        n_error_flags  = r_error_flags;
        final_ok       = 1'b0;
        o_res_valid    = 1'b0;
        o_res          = '0;

        if (!i_cmd) begin
            n_phase        = PH_A0;
            n_start_word   = '0;
            n_end_word     = '0;
            n_exec_word    = '0;
            n_type_byte    = '0;
            n_frame_length = '0;
            n_name_index   = '0;
            n_header_sum   = '0;
            n_data_sum     = '0;
            n_data_index   = '0;
            n_error_flags  = '0;
        end else if (r_phase != PH_IDLE && r_phase != PH_DONE) begin
            if (r_phase <= PH_NAME) begin
                n_header_sum = r_header_sum + i_link_byte;
            end
            unique case (r_phase)
                PH_A0: begin
                    n_start_word = {8'd0, i_link_byte};
                    n_phase      = PH_A1;
                end
                PH_A1: begin
                    n_start_word = {i_link_byte, r_start_word[7:0]};
                    n_phase      = PH_A2;
                end
                PH_A2: begin
                    n_end_word = {8'd0, i_link_byte};
                    n_phase    = PH_A3;
                end
                PH_A3: begin
                    n_end_word = {i_link_byte, r_end_word[7:0]};
                    n_phase    = PH_A4;
                end
                PH_A4: begin
                    n_exec_word = {8'd0, i_link_byte};
                    n_phase     = PH_A5;
                end
                PH_A5: begin
                    n_exec_word    = {i_link_byte, r_exec_word[7:0]};
                    // zero length means a full 64K frame
                    n_frame_length = {(len16 == '0), len16};
                    n_phase        = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type_byte = i_link_byte;
                    n_phase     = PH_NAME;
                end
                PH_NAME: begin
                    if (i_link_byte == '0) begin
                        n_phase = PH_HSUM;
                    end else if (r_name_index < cffr_pkg::NAME_IDX_W'(cffr_pkg::NAME_MAX)) begin
                        n_name_index         = r_name_index + 1'b1;
                        o_res_valid          = 1'b1;
                        o_res.item_kind      = cffr_pkg::KIND_NAME;
                        o_res.position       = cffr_pkg::ADDR_W'(r_name_index);
                        o_res.store_byte     = i_link_byte;
                    end
                end
                PH_HSUM: begin
                    if (r_header_sum != i_link_byte) begin
                        n_error_flags[cffr_pkg::ERR_HEADER] = 1'b1;
                    end
                    n_data_sum   = '0;
                    n_data_index = '0;
                    n_phase      = PH_DATA;
                end
                PH_DATA: begin
                    n_data_index = r_data_index + 1'b1;
                    n_data_sum   = r_data_sum + i_link_byte;
                    if (n_data_index[cffr_pkg::BLK_W-1:0] == '0) begin
                        n_phase = PH_BSUM;
                    end else if (n_data_index == r_frame_length) begin
                        n_phase = PH_FSUM;
                    end
                    if (r_data_index < cffr_pkg::COUNT_W'(cffr_pkg::BUFFER_DEPTH)) begin
                        o_res_valid      = 1'b1;
                        o_res.item_kind  = cffr_pkg::KIND_DATA;
                        o_res.position   = r_data_index[cffr_pkg::ADDR_W-1:0];
                        o_res.store_byte = i_link_byte;
                    end
                end
                PH_BSUM: begin
                    if (r_data_sum != i_link_byte) begin
                        n_error_flags[cffr_pkg::ERR_BLOCK] = 1'b1;
                    end
                    n_phase = (r_data_index == r_frame_length) ? PH_FSUM : PH_DATA;
                end
                PH_FSUM: begin
                    final_ok = (r_data_sum == i_link_byte);
                    if (!final_ok) begin
                        n_error_flags[cffr_pkg::ERR_FINAL] = 1'b1;
                    end
                    n_phase             = PH_DONE;
                    o_res_valid         = 1'b1;
                    o_res.item_kind     = cffr_pkg::KIND_STATUS;
                    o_res.start_address = r_start_word;
                    o_res.end_address   = r_end_word;
                    o_res.exec_address  = r_exec_word;
                    o_res.file_type     = r_type_byte;
                    o_res.byte_count    = r_data_index;
                    o_res.error_bits    = n_error_flags;
                    o_res.save_allowed  = final_ok;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_start_word   <= '0;
            r_end_word     <= '0;
            r_exec_word    <= '0;
            r_type_byte    <= '0;
            r_frame_length <= '0;
            r_name_index   <= '0;
            r_header_sum   <= '0;
            r_data_sum     <= '0;
            r_data_index   <= '0;
            r_error_flags  <= '0;
        end else if (i_take) begin
            r_phase        <= n_phase;
            r_start_word   <= n_start_word;
            r_end_word     <= n_end_word;
            r_exec_word    <= n_exec_word;
            r_type_byte    <= n_type_byte;
            r_frame_length <= n_frame_length;
            r_name_index   <= n_name_index;
            r_header_sum   <= n_header_sum;
            r_data_sum     <= n_data_sum;
            r_data_index   <= n_data_index;
            r_error_flags  <= n_error_flags;
        end
    end

`ifndef SYNTH
    a_name_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_name_index <= cffr_pkg::NAME_IDX_W'(cffr_pkg::NAME_MAX))
        else $error("name index past limit");

    a_data_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_data_index < r_frame_length))
        else $error("data index reached frame length while in data phase");

    a_final_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DONE) |-> !r_error_flags[cffr_pkg::ERR_FINAL])
        else $error("final error flag set before frame end");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !i_cmd) |=> (r_phase == PH_A0 && r_error_flags == '0
                                && r_header_sum == '0))
        else $error("start word did not clear the frame");
`endif

endmodule

// ----- src/cffr_out_buf.sv -----
// ----------------------------------------------------------------------------
// cffr_out_buf
// Two-entry result buffer: output register plus skid register, so the input
// side keeps taking words while a result waits.
// ----------------------------------------------------------------------------
module cffr_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cffr_pkg::t_result  i_data,
    output logic               o_space,
    output logic               o_valid,
    output cffr_pkg::t_result  o_data,
    input  logic               i_ready
);

    logic               r_out_valid;
    logic               r_skid_valid;
    cffr_pkg::t_result  r_out;
    cffr_pkg::t_result  r_skid;
    logic               out_take;

    assign out_take = r_out_valid && i_ready;
    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || out_take) begin
                r_out       <= i_data;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_data;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// ----- src/checksummed_file_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// checksummed_file_frame_receiver_top
// Deframes a checksummed file-write transfer, one link word per cycle while o_ready is high.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready): i_cmd 0 opens a new frame, i_cmd 1
// carries a link word in i_link_byte. Output channel (o_valid / i_ready):
// one result word per name character (up to NAME_MAX), per data word and one status word at
// frame end; o_item_kind tells them apart.
// Path: a result is registered in the output register, or in the skid
// register while the output stalls. Throughput: one input word per cycle
// while o_ready is high; the frame state updates in a single register stage.
// A two-entry output buffer (output register plus skid register) sits after
// the parser. When the receiver stalls, one more result is held in the skid
// register and o_ready drops until it drains; the result order is kept.
// Reset clears the frame state; words before the first start word and after
// the status word produce no result.
// ----------------------------------------------------------------------------
module checksummed_file_frame_receiver_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_cmd,
    input  logic [cffr_pkg::BYTE_W-1:0]     i_link_byte,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_item_kind,
    output logic [cffr_pkg::ADDR_W-1:0]     o_position,
    output logic [cffr_pkg::BYTE_W-1:0]     o_store_byte,
    output logic [cffr_pkg::ADDR_W-1:0]     o_start_address,
    output logic [cffr_pkg::ADDR_W-1:0]     o_end_address,
    output logic [cffr_pkg::ADDR_W-1:0]     o_exec_address,
    output logic [cffr_pkg::BYTE_W-1:0]     o_file_type,
    output logic [cffr_pkg::COUNT_W-1:0]    o_byte_count,
    output logic [cffr_pkg::ERR_W-1:0]      o_error_bits,
    output logic                            o_save_allowed
);

    logic               take;
    logic               res_valid;
    cffr_pkg::t_result  res;
    cffr_pkg::t_result  out_res;
    logic               space;

    assign o_ready = space;
    assign take    = i_valid && space;

    cffr_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_cmd       (i_cmd),
        .i_link_byte (i_link_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cffr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take && res_valid),
        .i_data  (res),
        .o_space (space),
        .o_valid (o_valid),
        .o_data  (out_res),
        .i_ready (i_ready)
    );

    assign o_item_kind     = out_res.item_kind;
    assign o_position      = out_res.position;
    assign o_store_byte    = out_res.store_byte;
    assign o_start_address = out_res.start_address;
    assign o_end_address   = out_res.end_address;
    assign o_exec_address  = out_res.exec_address;
    assign o_file_type     = out_res.file_type;
    assign o_byte_count    = out_res.byte_count;
    assign o_error_bits    = out_res.error_bits;
    assign o_save_allowed  = out_res.save_allowed;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the checksummed file frame receiver.
// Drives link words (start commands, frame headers, names, data and block
// sums, good and corrupted), tracks the frame parser in a local model and
// compares every name, data and status word with the model's prediction.
// Sender idling and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    typedef enum int {
        PACE_FLOW,
        PACE_SRC_IDLE,
        PACE_SNK_STALL,
        PACE_BOTH
    } t_pace;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_LO,
        ST_START_HI,
        ST_END_LO,
        ST_END_HI,
        ST_EXEC_LO,
        ST_EXEC_HI,
        ST_TYPE,
        ST_NAME,
        ST_HDR_SUM,
        ST_DATA,
        ST_BLK_SUM,
        ST_FIN_SUM,
        ST_DONE
    } t_parse;

    typedef struct {
        logic        cmd;
        logic [7:0]  data;
        t_pace       pace;
        bit          hold;
    } t_link_word;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic                           i_cmd = 1'b0;
    logic [cffr_pkg::BYTE_W-1:0]    i_link_byte = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [1:0]                     o_item_kind;
    logic [cffr_pkg::ADDR_W-1:0]    o_position;
    logic [cffr_pkg::BYTE_W-1:0]    o_store_byte;
    logic [cffr_pkg::ADDR_W-1:0]    o_start_address;
    logic [cffr_pkg::ADDR_W-1:0]    o_end_address;
    logic [cffr_pkg::ADDR_W-1:0]    o_exec_address;
    logic [cffr_pkg::BYTE_W-1:0]    o_file_type;
    logic [cffr_pkg::COUNT_W-1:0]   o_byte_count;
    logic [cffr_pkg::ERR_W-1:0]     o_error_bits;
    logic                           o_save_allowed;

    checksummed_file_frame_receiver_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_link_byte     (i_link_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_item_kind     (o_item_kind),
        .o_position      (o_position),
        .o_store_byte    (o_store_byte),
        .o_start_address (o_start_address),
        .o_end_address   (o_end_address),
        .o_exec_address  (o_exec_address),
        .o_file_type     (o_file_type),
        .o_byte_count    (o_byte_count),
        .o_error_bits    (o_error_bits),
        .o_save_allowed  (o_save_allowed)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_link_word           link_q[$];
    cffr_pkg::t_result    result_q[$];
    t_pace                cur_pace = PACE_FLOW;
    t_pace                rx_pace = PACE_FLOW;
    bit                   next_hold = 1'b0;
    bit                   word_taken = 1'b0;
    int                   fail_cnt = 0;
    int                   quiet_cycles = 0;

    // frame parser model
    t_parse                         st = ST_IDLE;
    logic [cffr_pkg::ADDR_W-1:0]    start_w = '0;
    logic [cffr_pkg::ADDR_W-1:0]    end_w = '0;
    logic [cffr_pkg::ADDR_W-1:0]    exec_w = '0;
    logic [cffr_pkg::BYTE_W-1:0]    type_b = '0;
    logic [cffr_pkg::COUNT_W-1:0]   frame_len = '0;
    int                             name_idx = 0;
    logic [cffr_pkg::BYTE_W-1:0]    hdr_sum = '0;
    logic [cffr_pkg::BYTE_W-1:0]    data_sum = '0;
    logic [cffr_pkg::COUNT_W-1:0]   data_idx = '0;
    logic [cffr_pkg::ERR_W-1:0]     err = '0;

    task automatic track_word(input logic cmd, input logic [7:0] x);
        cffr_pkg::t_result              r;
        bit                             emit;
        logic [cffr_pkg::COUNT_W-1:0]   pos;
        bit                             ok;
        r = '0;
        emit = 1'b0;
        if (!cmd) begin
            start_w = '0;
            end_w = '0;
            exec_w = '0;
            type_b = '0;
            frame_len = '0;
            name_idx = 0;
            hdr_sum = '0;
            data_sum = '0;
            data_idx = '0;
            err = '0;
            st = ST_START_LO;
        end else if (st != ST_IDLE && st != ST_DONE) begin
            if (st <= ST_NAME) hdr_sum = hdr_sum + x;
            unique case (st)
                ST_START_LO: begin
                    start_w = {8'h00, x};
                    st = ST_START_HI;
                end
                ST_START_HI: begin
                    start_w[15:8] = x;
                    st = ST_END_LO;
                end
                ST_END_LO: begin
                    end_w = {8'h00, x};
                    st = ST_END_HI;
                end
                ST_END_HI: begin
                    end_w[15:8] = x;
                    st = ST_EXEC_LO;
                end
                ST_EXEC_LO: begin
                    exec_w = {8'h00, x};
                    st = ST_EXEC_HI;
                end
                ST_EXEC_HI: begin
                    exec_w[15:8] = x;
                    frame_len = {1'b0, end_w - start_w + 16'd1};
                    if (frame_len == 0) frame_len = 17'h10000;
                    st = ST_TYPE;
                end
                ST_TYPE: begin
                    type_b = x;
                    st = ST_NAME;
                end
                ST_NAME: begin
                    if (x == 8'h00) begin
                        st = ST_HDR_SUM;
                    end else if (name_idx < cffr_pkg::NAME_MAX) begin
                        r.item_kind = cffr_pkg::KIND_NAME;
                        r.position = name_idx[cffr_pkg::ADDR_W-1:0];
                        r.store_byte = x;
                        name_idx++;
                        emit = 1'b1;
                    end
                end
                ST_HDR_SUM: begin
                    if (hdr_sum != x) err[cffr_pkg::ERR_HEADER] = 1'b1;
                    data_sum = '0;
                    data_idx = '0;
                    st = ST_DATA;
                end
                ST_DATA: begin
                    pos = data_idx;
                    data_idx = data_idx + 1'b1;
                    data_sum = data_sum + x;
                    if (data_idx % cffr_pkg::BLOCK_BYTES == 0) st = ST_BLK_SUM;
                    else if (data_idx == frame_len) st = ST_FIN_SUM;
                    if (pos < cffr_pkg::BUFFER_DEPTH) begin
                        r.item_kind = cffr_pkg::KIND_DATA;
                        r.position = pos[cffr_pkg::ADDR_W-1:0];
                        r.store_byte = x;
                        emit = 1'b1;
                    end
                end
                ST_BLK_SUM: begin
                    if (data_sum != x) err[cffr_pkg::ERR_BLOCK] = 1'b1;
                    st = (data_idx == frame_len) ? ST_FIN_SUM : ST_DATA;
                end
                ST_FIN_SUM: begin
                    ok = (data_sum == x);
                    if (!ok) err[cffr_pkg::ERR_FINAL] = 1'b1;
                    st = ST_DONE;
                    r.item_kind = cffr_pkg::KIND_STATUS;
                    r.start_address = start_w;
                    r.end_address = end_w;
                    r.exec_address = exec_w;
                    r.file_type = type_b;
                    r.byte_count = data_idx;
                    r.error_bits = err;
                    r.save_allowed = ok;
                    emit = 1'b1;
                end
                default: ;
            endcase
        end
        if (emit) result_q.push_back(r);
    endtask

    task automatic push_word(input logic cmd, input logic [7:0] data);
        link_q.push_back('{cmd, data, cur_pace, next_hold});
        next_hold = 1'b0;
    endtask

    // one write transfer; broken cuts it short at a random word
    task automatic queue_frame(input logic [15:0] s, input int len, input int name_len,
                               input bit bad_hdr, input bit bad_blk, input bit bad_fin,
                               input bit broken);
        logic [7:0]   fb[$];
        logic [15:0]  e;
        logic [15:0]  xa;
        logic [7:0]   hs;
        logic [7:0]   ds;
        logic [7:0]   c;
        int           k;
        e = s + len[15:0] - 16'd1;
        xa = 16'($urandom);
        fb = {s[7:0], s[15:8], e[7:0], e[15:8], xa[7:0], xa[15:8], 8'($urandom)};
        for (int i = 0; i < name_len; i++) fb.push_back(8'($urandom_range(1, 255)));
        fb.push_back(8'h00);
        hs = '0;
        foreach (fb[i]) hs = hs + fb[i];
        fb.push_back(bad_hdr ? hs ^ 8'($urandom_range(1, 255)) : hs);
        ds = '0;
        for (int i = 0; i < len; i++) begin
            c = 8'($urandom);
            ds = ds + c;
            fb.push_back(c);
            if ((i + 1) % cffr_pkg::BLOCK_BYTES == 0)
                fb.push_back(bad_blk ? ds ^ 8'($urandom_range(1, 255)) : ds);
        end
        fb.push_back(bad_fin ? ds ^ 8'($urandom_range(1, 255)) : ds);
        if (broken) begin
            k = $urandom_range(0, fb.size() - 1);
            while (fb.size() > k) fb.delete(fb.size() - 1);
        end
        push_word(1'b0, 8'($urandom));
        foreach (fb[i]) push_word(1'b1, fb[i]);
    endtask

    function automatic bit roll_pct(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    // input acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            track_word(i_cmd, i_link_byte);
            word_taken = 1'b1;
        end
    end

    // driver
    always @(negedge i_clk) begin : drv
        t_link_word w;
        int         src_pct;
        int         snk_pct;
        if (i_rst_n) begin
            if (!i_valid || word_taken) begin
                word_taken = 1'b0;
                src_pct = 0;
                if (link_q.size() != 0)
                    src_pct = (link_q[0].pace == PACE_SRC_IDLE) ? 82 :
                              (link_q[0].pace == PACE_BOTH) ? 31 : 0;
                if (link_q.size() != 0 && !(link_q[0].hold && result_q.size() != 0) &&
                    !roll_pct(src_pct)) begin
                    w = link_q.pop_front();
                    rx_pace = w.pace;
                    i_valid <= 1'b1;
                    i_cmd <= w.cmd;
                    i_link_byte <= w.data;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            snk_pct = (rx_pace == PACE_SNK_STALL) ? 82 : (rx_pace == PACE_BOTH) ? 31 : 0;
            i_ready <= !roll_pct(snk_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        cffr_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (result_q.size() == 0) begin
                $error("unexpected result word: kind %0d position 0x%0h",
                       o_item_kind, o_position);
                fail_cnt++;
            end else begin
                want = result_q.pop_front();
                compare_field("item_kind", 32'(want.item_kind), 32'(o_item_kind));
                compare_field("position", 32'(want.position), 32'(o_position));
                compare_field("store_byte", 32'(want.store_byte), 32'(o_store_byte));
                compare_field("start_address", 32'(want.start_address),
                              32'(o_start_address));
                compare_field("end_address", 32'(want.end_address), 32'(o_end_address));
                compare_field("exec_address", 32'(want.exec_address),
                              32'(o_exec_address));
                compare_field("file_type", 32'(want.file_type), 32'(o_file_type));
                compare_field("byte_count", 32'(want.byte_count), 32'(o_byte_count));
                compare_field("error_bits", 32'(want.error_bits), 32'(o_error_bits));
                compare_field("save_allowed", 32'(want.save_allowed),
                              32'(o_save_allowed));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : stim
        int          target;
        int          roll;
        int          len;
        int          name_len;
        logic [7:0]  wq[$];
        logic [7:0]  wsum;
        logic [7:0]  wb;
        // directed: stray words, cut frame, one-word frame with bad header sum,
        // words after status, then a start on top of a live frame
        push_word(1'b1, 8'hA5);
        push_word(1'b1, 8'h5A);
        queue_frame(16'h0000, 5, 2, 1'b0, 1'b0, 1'b0, 1'b1);
        queue_frame(16'hFFFF, 1, 2, 1'b1, 1'b0, 1'b0, 1'b0);
        push_word(1'b1, 8'h00);
        push_word(1'b1, 8'hFF);
        push_word(1'b0, 8'hFF);
        push_word(1'b1, 8'h12);
        queue_frame(16'h8000, 2, 0, 1'b0, 1'b0, 1'b1, 1'b0);

        // start 0x0001, end 0x0000: length wraps to 64K; cut after the first
        // block sum and a few more data words
        wq = {8'h01, 8'h00, 8'h00, 8'h00, 8'h34, 8'h12, 8'h7E, 8'h41, 8'h00};
        wsum = '0;
        foreach (wq[i]) wsum = wsum + wq[i];
        wq.push_back(wsum);
        wsum = '0;
        for (int i = 0; i < cffr_pkg::BLOCK_BYTES + 4; i++) begin
            wb = 8'($urandom);
            wsum = wsum + wb;
            wq.push_back(wb);
            if (i + 1 == cffr_pkg::BLOCK_BYTES) wq.push_back(wsum);
        end
        push_word(1'b0, 8'h00);
        foreach (wq[i]) push_word(1'b1, wq[i]);

        for (int ph = 0; ph < 4; ph++) begin
            cur_pace = t_pace'(ph);
            next_hold = 1'b1;
            target = link_q.size() + 340;
            while (link_q.size() < target) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    repeat ($urandom_range(1, 6))
                        push_word(($urandom_range(0, 7) != 0), 8'($urandom));
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70) len = $urandom_range(1, 32);
                    else if (roll < 85) len = $urandom_range(1, 8);
                    else if (roll < 93) len = $urandom_range(250, 262);
                    else if (roll < 98) len = cffr_pkg::BLOCK_BYTES;
                    else len = 2 * cffr_pkg::BLOCK_BYTES;
                    roll = $urandom_range(0, 99);
                    if (roll < 60) name_len = $urandom_range(0, 6);
                    else if (roll < 85) name_len = $urandom_range(7, cffr_pkg::NAME_MAX);
                    else name_len = $urandom_range(cffr_pkg::NAME_MAX + 1,
                                                   cffr_pkg::NAME_MAX + 8);
                    queue_frame(16'($urandom), len, name_len, roll_pct(15), roll_pct(15),
                                roll_pct(15), roll_pct(10));
                    if (roll_pct(25))
                        repeat ($urandom_range(1, 3)) push_word(1'b1, 8'($urandom));
                end
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (link_q.size() != 0 || i_valid) @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
